FILE: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types and constants for the rational arithmetic unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 72;

    localparam int OUT_NUM_LSB   = 0;
    localparam int OUT_DEN_LSB   = 32;
    localparam int OUT_LESS_BIT  = 63;
    localparam int OUT_EQUAL_BIT = 64;
    localparam int OUT_GREAT_BIT = 65;
    localparam int OUT_DZ_BIT    = 66;
    localparam int OUT_WIDE_BIT  = 67;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_MUL1 = 12'b0000_0000_0010,
        ST_MUL2 = 12'b0000_0000_0100,
        ST_MUL3 = 12'b0000_0000_1000,
        ST_MUL4 = 12'b0000_0001_0000,
        ST_COMB = 12'b0000_0010_0000,
        ST_ABS  = 12'b0000_0100_0000,
        ST_TWOS = 12'b0000_1000_0000,
        ST_GCD  = 12'b0001_0000_0000,
        ST_DIV  = 12'b0010_0000_0000,
        ST_FIN  = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

FILE: design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions, reduces the result to
// lowest terms and compares the two operands.
// ----------------------------------------------------------------------------
// One beat is taken at a time: the block is not ready from the accepted input
// beat until its result beat has been taken. An item runs through the products,
// the removal of the T common factors of two in the unreduced result, G binary
// GCD steps (at most about 380) and two 64-step restoring divisions by the GCD.
// One 32 by 32 multiplier forms the cross products in three steps, or four for
// multiply, and one 64-bit subtract and compare unit runs the GCD and the
// divisions. VALUE_WIDTH sets the bound at which result parts are clamped.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // func[1:0], a_num[33:2], a_den[64:34], b_num[96:65], b_den[127:97]
    input  wire logic [rau_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // res_num[31:0], res_den[62:32], less, equal, greater, div_zero,
    // too_wide[67], zeros[71:68]
    output logic [rau_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    import rau_pkg::*;

    localparam logic [63:0] MAXV = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    localparam int          DIV_STEPS = 64;
    localparam logic [5:0]  LAST_STEP = 6'(DIV_STEPS - 1);

    state_t state_reg, state_next;

    func_t              func_reg, func_next;
    logic signed [31:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [31:0] bn_reg, bn_next, bd_reg, bd_next;
    logic signed [63:0] x1_reg, x1_next, x2_reg, x2_next;
    logic signed [63:0] dp_reg, dp_next, np_reg, np_next;
    logic signed [63:0] n_reg, n_next;
    logic [63:0]        mn_reg, mn_next, md_reg, md_next;
    logic [63:0]        u_reg, u_next, v_reg, v_next;
    logic [63:0]        q_reg, q_next, rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               sel_reg, sel_next, neg_reg, neg_next;
    logic               lt_reg, lt_next, eq_reg, eq_next, gt_reg, gt_next;
    logic               dz_reg, dz_next, wide_reg, wide_next;
    logic [31:0]        rnum_reg, rnum_next;
    logic [30:0]        rden_reg, rden_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic [64:0]        rem_sh;
    logic [64:0]        sub_x, sub_y, sub_diff;
    logic               sub_ge;
    logic               rem_ge;
    logic [63:0]        rem_step, q_step;
    logic [63:0]        mn_clamp, md_clamp;
    logic [30:0]        a_den_in, b_den_in;

    assign a_den_in = s_axis_tdata[64:34];
    assign b_den_in = s_axis_tdata[127:97];

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            ST_MUL2:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            ST_MUL3:
            begin
                mul_a = ad_reg;
                mul_b = (func_reg == FUNC_DIV) ? bn_reg : bd_reg;
            end
            ST_MUL4:
            begin
                mul_a = an_reg;
                mul_b = bn_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign rem_sh = {rem_reg, q_reg[63]};

    always_comb
    begin
        sub_x = rem_sh;
        sub_y = {1'b0, v_reg};
        if (state_reg == ST_GCD)
        begin
            sub_x = {1'b0, u_reg};
        end
    end

    assign sub_ge   = sub_x >= sub_y;
    assign sub_diff = sub_x - sub_y;

    assign rem_ge   = sub_ge;
    assign rem_step = rem_ge ? sub_diff[63:0] : rem_sh[63:0];
    assign q_step   = {q_reg[62:0], rem_ge};

    assign mn_clamp = (mn_reg > MAXV) ? MAXV : mn_reg;
    assign md_clamp = (md_reg > MAXV) ? MAXV : md_reg;

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        dp_next    = dp_reg;
        np_next    = np_reg;
        n_next     = n_reg;
        mn_next    = mn_reg;
        md_next    = md_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        neg_next   = neg_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        gt_next    = gt_reg;
        dz_next    = dz_reg;
        wide_next  = wide_reg;
        rnum_next  = rnum_reg;
        rden_next  = rden_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next  = func_t'(s_axis_tdata[1:0]);
                    an_next    = s_axis_tdata[33:2];
                    ad_next    = {1'b0, (a_den_in == 31'd0) ? 31'd1 : a_den_in};
                    bn_next    = s_axis_tdata[96:65];
                    bd_next    = {1'b0, (b_den_in == 31'd0) ? 31'd1 : b_den_in};
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                x1_next    = prod;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                x2_next    = prod;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                dp_next    = prod;
                lt_next    = x1_reg < x2_reg;
                eq_next    = x1_reg == x2_reg;
                gt_next    = x1_reg > x2_reg;
                state_next = (func_reg == FUNC_MUL) ? ST_MUL4 : ST_COMB;
            end
            ST_MUL4:
            begin
                np_next    = prod;
                state_next = ST_COMB;
            end
            ST_COMB:
            begin
                dz_next    = 1'b0;
                md_next    = 64'(dp_reg);
                case (func_reg)
                    FUNC_ADD: n_next = x1_reg + x2_reg;
                    FUNC_SUB: n_next = x1_reg - x2_reg;
                    FUNC_MUL: n_next = np_reg;
                    FUNC_DIV:
                    begin
                        if (bn_reg == 32'sd0)
                        begin
                            dz_next = 1'b1;
                            n_next  = 64'sd0;
                            md_next = 64'd1;
                        end
                        else if (dp_reg < 64'sd0)
                        begin
                            n_next  = -x1_reg;
                            md_next = 64'(-dp_reg);
                        end
                        else
                        begin
                            n_next  = x1_reg;
                        end
                    end
                    default: n_next = x1_reg;
                endcase
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                neg_next = n_reg[63];
                mn_next  = n_reg[63] ? 64'(-n_reg) : 64'(n_reg);
                if (n_reg == 64'sd0)
                begin
                    md_next    = 64'd1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_TWOS;
                end
            end
            ST_TWOS:
            begin
                if (!mn_reg[0] && !md_reg[0])
                begin
                    mn_next = mn_reg >> 1;
                    md_next = md_reg >> 1;
                end
                else
                begin
                    u_next     = mn_reg;
                    v_next     = md_reg;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (u_reg == 64'd0)
                begin
                    q_next     = mn_reg;
                    rem_next   = 64'd0;
                    cnt_next   = 6'd0;
                    sel_next   = 1'b0;
                    state_next = ST_DIV;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (sub_ge)
                begin
                    u_next = sub_diff[63:0];
                end
                else
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                q_next   = q_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    if (!sel_reg)
                    begin
                        mn_next  = q_step;
                        q_next   = md_reg;
                        rem_next = 64'd0;
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        md_next    = q_step;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                wide_next  = (mn_reg > MAXV) || (md_reg > MAXV);
                rnum_next  = neg_reg ? 32'(-mn_clamp[31:0]) : mn_clamp[31:0];
                rden_next  = md_clamp[30:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        x1_reg   <= x1_next;
        x2_reg   <= x2_next;
        dp_reg   <= dp_next;
        np_reg   <= np_next;
        n_reg    <= n_next;
        mn_reg   <= mn_next;
        md_reg   <= md_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        sel_reg  <= sel_next;
        neg_reg  <= neg_next;
        lt_reg   <= lt_next;
        eq_reg   <= eq_next;
        gt_reg   <= gt_next;
        dz_reg   <= dz_next;
        wide_reg <= wide_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {4'd0, wide_reg, dz_reg, gt_reg, eq_reg, lt_reg,
                            rden_reg, rnum_reg};

endmodule

`default_nettype wire

FILE: design/rau_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level assertions on the rational arithmetic unit, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic [rau_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [rau_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import rau_pkg::*;

    logic       cmp_less, cmp_equal, cmp_great, dz, wide;
    logic [31:0] rnum;
    logic [30:0] rden;

    assign cmp_less  = m_axis_tdata[OUT_LESS_BIT];
    assign cmp_equal = m_axis_tdata[OUT_EQUAL_BIT];
    assign cmp_great = m_axis_tdata[OUT_GREAT_BIT];
    assign dz        = m_axis_tdata[OUT_DZ_BIT];
    assign wide      = m_axis_tdata[OUT_WIDE_BIT];
    assign rnum      = m_axis_tdata[OUT_NUM_LSB +: 32];
    assign rden      = m_axis_tdata[OUT_DEN_LSB +: 31];

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("Input beat offered while a result beat is pending.");

    a_one_compare_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot({cmp_less, cmp_equal, cmp_great}))
        else $error("Comparison flags are not exactly one.");

    a_div_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && dz) |-> (rnum == 32'd0 && rden == 31'd1 && !wide))
        else $error("Division by zero did not give a clean zero result.");

    a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Stalled result beat changed.");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

`default_nettype wire

FILE: tb/sv/rational_arithmetic_unit_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches both stream channels, works out the reduced fraction and the
// comparison flags for every accepted input beat, and compares each output
// beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module rational_arithmetic_unit_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [rau_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [rau_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                                   failures,
    output int                                   pending
);

    import rau_pkg::*;

    typedef struct packed {
        logic        too_wide;
        logic        div_zero;
        logic        greater;
        logic        equal;
        logic        less;
        logic [30:0] res_den;
        logic [31:0] res_num;
    } fraction_result_t;

    fraction_result_t expected_fractions[$];

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic fraction_result_t reduce_item(logic [IN_TDATA_W-1:0] d);
        func_t            op;
        longint           an, bn, ad, bd, x1, x2, n, dn;
        longint unsigned  mn, md, g, lim;
        logic             neg;
        fraction_result_t r;
        op  = func_t'(d[1:0]);
        an  = longint'(signed'(d[33:2]));
        ad  = (d[64:34] == 0) ? 1 : longint'({1'b0, d[64:34]});
        bn  = longint'(signed'(d[96:65]));
        bd  = (d[127:97] == 0) ? 1 : longint'({1'b0, d[127:97]});
        lim = (64'd1 << (VALUE_WIDTH - 1)) - 1;
        x1  = an * bd;
        x2  = bn * ad;
        r   = '0;
        n   = 0;
        dn  = 1;
        case (op)
            FUNC_ADD:
            begin
                n  = x1 + x2;
                dn = ad * bd;
            end
            FUNC_SUB:
            begin
                n  = x1 - x2;
                dn = ad * bd;
            end
            FUNC_MUL:
            begin
                n  = an * bn;
                dn = ad * bd;
            end
            default:
            begin
                if (bn == 0)
                begin
                    r.div_zero = 1'b1;
                end
                else
                begin
                    n  = x1;
                    dn = ad * bn;
                    if (dn < 0)
                    begin
                        n  = -n;
                        dn = -dn;
                    end
                end
            end
        endcase
        neg = n < 0;
        mn  = neg ? 64'd0 - 64'(n) : 64'(n);
        md  = 64'(dn);
        if (mn == 0)
        begin
            md = 1;
        end
        else
        begin
            g  = euclid_gcd(mn, md);
            mn = mn / g;
            md = md / g;
        end
        if (mn > lim)
        begin
            mn         = lim;
            r.too_wide = 1'b1;
        end
        if (md > lim)
        begin
            md         = lim;
            r.too_wide = 1'b1;
        end
        r.res_num = neg ? 32'(64'd0 - mn) : mn[31:0];
        r.res_den = md[30:0];
        r.less    = x1 < x2;
        r.equal   = x1 == x2;
        r.greater = x1 > x2;
        return r;
    endfunction

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            failures++;
        end
    endtask

    assign pending = expected_fractions.size();

    initial failures = 0;

    always @(posedge clk)
    begin
        fraction_result_t e;
        fraction_result_t a;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_fractions.push_back(reduce_item(s_axis_tdata));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a = m_axis_tdata[67:0];
            if (expected_fractions.size() == 0)
            begin
                $error("Output beat with no prediction outstanding");
                failures++;
            end
            else
            begin
                e = expected_fractions.pop_front();
                compare_field("res_num", longint'(signed'(e.res_num)),
                              longint'(signed'(a.res_num)));
                compare_field("res_den", e.res_den, a.res_den);
                compare_field("less", e.less, a.less);
                compare_field("equal", e.equal, a.equal);
                compare_field("greater", e.greater, a.greater);
                compare_field("div_zero", e.div_zero, a.div_zero);
                compare_field("too_wide", e.too_wide, a.too_wide);
                compare_field("padding", 0, m_axis_tdata[71:68]);
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed corner fractions and then random ones, with random gaps on
// the input side and random stalls on the output side, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int                     failures;
    int                     pending;
    logic                   steady;

    rational_arithmetic_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rational_arithmetic_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .failures(failures), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 12);
    end

    function automatic logic [31:0] pick_num();
        case ($urandom_range(7))
            0:       return 32'h8000_0000 + $urandom_range(1);
            1:       return 32'h7FFF_FFFF - $urandom_range(1);
            2:       return 32'($signed($urandom_range(40)) - 20);
            3:       return 32'($signed($urandom_range(2000)) - 1000);
            4:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(6))
            0:       return 31'(31'h7FFF_FFFF - $urandom_range(1));
            1:       return 31'($urandom_range(12));
            2:       return 31'($urandom_range(1000, 1));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send_fraction(func_t op, logic [31:0] an, logic [30:0] ad,
                                 logic [31:0] bn, logic [30:0] bd);
        while (!steady && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bd, bn, ad, an, op};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int     waited;
        func_t  op;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 4; k++)
        begin
            op = func_t'(k);
            send_fraction(op, 32'h7FFF_FFFF, 31'd1, 32'h8000_0001, 31'd1);
            send_fraction(op, 32'h8000_0000, 31'd3, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
            send_fraction(op, 32'd3, 31'd0, 32'hFFFF_FFFE, 31'd0);
            send_fraction(op, 32'd1, 31'd2, 32'd2, 31'd4);
            send_fraction(op, 32'd0, 31'd5, 32'd0, 31'd7);
        end
        send_fraction(FUNC_DIV, 32'd5, 31'd3, 32'hFFFF_FFF9, 31'd2);
        send_fraction(FUNC_SUB, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE);
        send_fraction(FUNC_MUL, 32'hFFFF_FFFF, 31'h5555_5555, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
        for (int i = 0; i < 550; i++)
        begin
            steady = (i >= 200 && i < 260);
            op = func_t'($urandom_range(3));
            send_fraction(op, pick_num(), pick_den(), pick_num(), pick_den());
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
